@@ sv/epr_pkg.sv @@
// Shared types and constants for the Euler point rotator.
`timescale 1ns / 1ps

package epr_pkg;

    localparam int COORD_W       = 16;
    localparam int ANG_W         = 10;
    localparam int COEF_W        = 16;
    localparam int FRAC_W        = 15;
    localparam int PROD_W        = COORD_W + COEF_W;
    localparam int SUM_W         = PROD_W + 1;
    localparam int HALF_TURN_DEF = 512;
    localparam int TAYLOR_TERMS  = 12;
    localparam int Q30_SHIFT     = 30;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic        [ANG_W-1:0]   t_ang;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_REV = 1'b1
    } t_op;

    typedef struct packed {
        t_op    op;
        t_coord third;
        t_ang   ang_mid;
        t_ang   ang_last;
        logic   clip;
    } t_side;

endpackage

@@ sv/epr_rot_stage.sv @@
// One plane rotation: sine ROM read, four products, truncate and saturate.
`timescale 1ns / 1ps

module epr_rot_stage #(
    parameter int HALF_TURN = epr_pkg::HALF_TURN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  epr_pkg::t_coord i_a,
    input  epr_pkg::t_coord i_b,
    input  epr_pkg::t_ang  i_ang,
    input  logic           i_neg,
    input  epr_pkg::t_side i_side,
    output logic           o_vld,
    input  logic           i_rdy,
    output epr_pkg::t_coord o_a,
    output epr_pkg::t_coord o_b,
    output epr_pkg::t_side o_side
);

    localparam int ROM_DEPTH = 2 * HALF_TURN;
    localparam int AW        = $clog2(ROM_DEPTH);
    localparam int QUARTER   = HALF_TURN / 2;
    localparam int SAT_HI    = (1 << (epr_pkg::COORD_W - 1)) - 1;
    localparam int SAT_LO    = -(1 << (epr_pkg::COORD_W - 1));
    localparam int RND_ADD   = (1 << epr_pkg::FRAC_W) - 1;

    localparam epr_pkg::t_coef COEF_MIN = {1'b1, {(epr_pkg::COEF_W - 1){1'b0}}};

    typedef epr_pkg::t_coef t_rom [ROM_DEPTH];

    typedef struct packed {
        logic            clip;
        epr_pkg::t_coord val;
    } t_sat;

    function automatic logic [15:0] quad_sine(input int unsigned n);
        logic [63:0] theta;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        theta = (epr_pkg::PI_Q30 * 64'(n)) / 64'(HALF_TURN);
        term  = theta;
        sum   = signed'(theta);
        for (int i = 1; i <= epr_pkg::TAYLOR_TERMS; i++) begin
            term = (term * theta) >> epr_pkg::Q30_SHIFT;
            term = (term * theta) >> epr_pkg::Q30_SHIFT;
            term = term / 64'((2 * i) * (2 * i + 1));
            if (i[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (64'(sum) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom        tab;
        int unsigned n;
        logic        neg;
        logic [15:0] v;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            n   = k;
            neg = 1'b0;
            if (n >= HALF_TURN) begin
                n   = n - HALF_TURN;
                neg = 1'b1;
            end
            if (n > QUARTER) begin
                n = HALF_TURN - n;
            end
            v      = quad_sine(n);
            tab[k] = neg ? epr_pkg::t_coef'(16'd0 - v) : epr_pkg::t_coef'(v);
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    function automatic t_sat trunc_sat(input logic signed [epr_pkg::SUM_W-1:0] s);
        logic signed [epr_pkg::SUM_W-1:0] q;
        t_sat                             res;
        q = (s + (s[epr_pkg::SUM_W-1] ? epr_pkg::SUM_W'(RND_ADD) : epr_pkg::SUM_W'(0)))
            >>> epr_pkg::FRAC_W;
        if (q > epr_pkg::SUM_W'(SAT_HI)) begin
            res.clip = 1'b1;
            res.val  = epr_pkg::t_coord'(SAT_HI);
        end else if (q < epr_pkg::SUM_W'(SAT_LO)) begin
            res.clip = 1'b1;
            res.val  = epr_pkg::t_coord'(SAT_LO);
        end else begin
            res.clip = 1'b0;
            res.val  = q[epr_pkg::COORD_W-1:0];
        end
        return res;
    endfunction

    logic [AW-1:0] w_idx_base;
    logic [AW-1:0] w_idx;
    logic [AW-1:0] w_idx_cos;
    logic          w_en1;
    logic          w_en2;
    logic          w_en3;

    logic                                r_v1;
    epr_pkg::t_coef                      r_sin;
    epr_pkg::t_coef                      r_cos;
    epr_pkg::t_coord                     r_a1;
    epr_pkg::t_coord                     r_b1;
    epr_pkg::t_side                      r_side1;

    logic                                r_v2;
    logic signed [epr_pkg::PROD_W-1:0]   r_p_ca;
    logic signed [epr_pkg::PROD_W-1:0]   r_p_sb;
    logic signed [epr_pkg::PROD_W-1:0]   r_p_cb;
    logic signed [epr_pkg::PROD_W-1:0]   r_p_sa;
    epr_pkg::t_side                      r_side2;

    logic                                r_v3;
    epr_pkg::t_coord                     r_o_a;
    epr_pkg::t_coord                     r_o_b;
    epr_pkg::t_side                      r_side3;

    logic signed [epr_pkg::SUM_W-1:0]    w_s1;
    logic signed [epr_pkg::SUM_W-1:0]    w_s2;
    t_sat                                w_q1;
    t_sat                                w_q2;
    epr_pkg::t_side                      n_side3;

    assign w_en3 = !r_v3 || i_rdy;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_rdy = w_en1;

    assign w_idx_base = AW'(i_ang);
    assign w_idx      = i_neg ? (AW'(0) - w_idx_base) : w_idx_base;
    assign w_idx_cos  = w_idx + AW'(QUARTER);

    always_comb begin
        w_s1         = epr_pkg::SUM_W'(r_p_ca) - epr_pkg::SUM_W'(r_p_sb);
        w_s2         = epr_pkg::SUM_W'(r_p_cb) + epr_pkg::SUM_W'(r_p_sa);
        w_q1         = trunc_sat(w_s1);
        w_q2         = trunc_sat(w_s2);
        n_side3      = r_side2;
        n_side3.clip = r_side2.clip | w_q1.clip | w_q2.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_vld;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_sin   <= SINE_ROM[w_idx];
            r_cos   <= SINE_ROM[w_idx_cos];
            r_a1    <= i_a;
            r_b1    <= i_b;
            r_side1 <= i_side;
        end
        if (w_en2) begin
            r_p_ca  <= r_cos * r_a1;
            r_p_sb  <= r_sin * r_b1;
            r_p_cb  <= r_cos * r_b1;
            r_p_sa  <= r_sin * r_a1;
            r_side2 <= r_side1;
        end
        if (w_en3) begin
            r_o_a   <= w_q1.val;
            r_o_b   <= w_q2.val;
            r_side3 <= n_side3;
        end
    end

    assign o_vld  = r_v3;
    assign o_a    = r_o_a;
    assign o_b    = r_o_b;
    assign o_side = r_side3;

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_sin != COEF_MIN && r_cos != COEF_MIN))
        else $error("sine or cosine reached the negative full-scale code");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rdy |-> (r_v1 && r_v2 && r_v3))
        else $error("input blocked while a pipeline slot is empty");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1)
         && $past(i_vld && o_rdy, 3) && $past(i_rdy, 2) && $past(i_rdy, 1)) |-> o_vld)
        else $error("request did not reach the output in three cycles");

endmodule

@@ sv/euler_point_rotator_core.sv @@
// Top level of the Euler point rotator: three chained plane rotation stages.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  request  | i_in_valid  / o_in_ready     | i_op i_px i_py i_pz i_angle_yz/xz/xy
//  result   | o_out_valid / i_out_ready    | o_rx o_ry o_rz o_clipped
//
//  Three rotation stages, each with three registers (ROM read, products,
//  truncate and saturate). One point is taken every cycle while o_in_ready is high.
//  Each rotation stage owns a 2*HALF_TURN entry sine ROM with two read ports.
//  Reset clears the valid bits only; no clearing pass is needed.
//  A stalled output holds its result; empty slots in the pipeline still fill,
//  so requests keep being taken until every slot is occupied.
`timescale 1ns / 1ps

module euler_point_rotator_core #(
    parameter int HALF_TURN = epr_pkg::HALF_TURN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_op,
    input  epr_pkg::t_coord i_px,
    input  epr_pkg::t_coord i_py,
    input  epr_pkg::t_coord i_pz,
    input  epr_pkg::t_ang   i_angle_yz,
    input  epr_pkg::t_ang   i_angle_xz,
    input  epr_pkg::t_ang   i_angle_xy,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output epr_pkg::t_coord o_rx,
    output epr_pkg::t_coord o_ry,
    output epr_pkg::t_coord o_rz,
    output logic            o_clipped
);

    logic            w_rev1;
    logic            w_rev2;
    logic            w_rev3;
    logic            w_revo;

    epr_pkg::t_coord w_a1;
    epr_pkg::t_coord w_b1;
    epr_pkg::t_ang   w_ang1;
    epr_pkg::t_side  w_side1;

    logic            w_v1o;
    logic            w_r1o;
    epr_pkg::t_coord w_o1a;
    epr_pkg::t_coord w_o1b;
    epr_pkg::t_side  w_side1o;

    epr_pkg::t_coord w_a2;
    epr_pkg::t_coord w_b2;
    epr_pkg::t_side  w_side2;

    logic            w_v2o;
    logic            w_r2o;
    epr_pkg::t_coord w_o2a;
    epr_pkg::t_coord w_o2b;
    epr_pkg::t_side  w_side2o;

    epr_pkg::t_coord w_a3;
    epr_pkg::t_coord w_b3;
    epr_pkg::t_side  w_side3;

    epr_pkg::t_coord w_o3a;
    epr_pkg::t_coord w_o3b;
    epr_pkg::t_side  w_side3o;

    // Route the first plane: yz forward, xy reversed.
    always_comb begin
        w_rev1           = (epr_pkg::t_op'(i_op) == epr_pkg::OP_REV);
        w_a1             = w_rev1 ? i_px : i_py;
        w_b1             = w_rev1 ? i_py : i_pz;
        w_ang1           = w_rev1 ? i_angle_xy : i_angle_yz;
        w_side1.op       = epr_pkg::t_op'(i_op);
        w_side1.third    = w_rev1 ? i_pz : i_px;
        w_side1.ang_mid  = i_angle_xz;
        w_side1.ang_last = w_rev1 ? i_angle_yz : i_angle_xy;
        w_side1.clip     = 1'b0;
    end

    epr_rot_stage #(
        .HALF_TURN (HALF_TURN)
    ) u_rot1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_a     (w_a1),
        .i_b     (w_b1),
        .i_ang   (w_ang1),
        .i_neg   (w_rev1),
        .i_side  (w_side1),
        .o_vld   (w_v1o),
        .i_rdy   (w_r1o),
        .o_a     (w_o1a),
        .o_b     (w_o1b),
        .o_side  (w_side1o)
    );

    // Route the xz plane in both modes.
    always_comb begin
        w_rev2        = (w_side1o.op == epr_pkg::OP_REV);
        w_a2          = w_rev2 ? w_o1a : w_side1o.third;
        w_b2          = w_rev2 ? w_side1o.third : w_o1b;
        w_side2       = w_side1o;
        w_side2.third = w_rev2 ? w_o1b : w_o1a;
    end

    epr_rot_stage #(
        .HALF_TURN (HALF_TURN)
    ) u_rot2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_v1o),
        .o_rdy   (w_r1o),
        .i_a     (w_a2),
        .i_b     (w_b2),
        .i_ang   (w_side1o.ang_mid),
        .i_neg   (w_rev2),
        .i_side  (w_side2),
        .o_vld   (w_v2o),
        .i_rdy   (w_r2o),
        .o_a     (w_o2a),
        .o_b     (w_o2b),
        .o_side  (w_side2o)
    );

    // Route the last plane: xy forward, yz reversed.
    always_comb begin
        w_rev3        = (w_side2o.op == epr_pkg::OP_REV);
        w_a3          = w_rev3 ? w_side2o.third : w_o2a;
        w_b3          = w_rev3 ? w_o2b : w_side2o.third;
        w_side3       = w_side2o;
        w_side3.third = w_rev3 ? w_o2a : w_o2b;
    end

    epr_rot_stage #(
        .HALF_TURN (HALF_TURN)
    ) u_rot3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_v2o),
        .o_rdy   (w_r2o),
        .i_a     (w_a3),
        .i_b     (w_b3),
        .i_ang   (w_side2o.ang_last),
        .i_neg   (w_rev3),
        .i_side  (w_side3),
        .o_vld   (o_out_valid),
        .i_rdy   (i_out_ready),
        .o_a     (w_o3a),
        .o_b     (w_o3b),
        .o_side  (w_side3o)
    );

    always_comb begin
        w_revo    = (w_side3o.op == epr_pkg::OP_REV);
        o_rx      = w_revo ? w_side3o.third : w_o3a;
        o_ry      = w_revo ? w_o3a : w_o3b;
        o_rz      = w_revo ? w_o3b : w_side3o.third;
        o_clipped = w_side3o.clip;
    end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for euler_point_rotator_core: request stream, predictor, result check.
`timescale 1ns / 1ps

module tb;

    localparam int          HALF_TURN    = epr_pkg::HALF_TURN_DEF;
    localparam int unsigned FULL_TURN    = 2 * HALF_TURN;
    localparam int unsigned ANG_MASK     = FULL_TURN - 1;
    localparam int unsigned QUARTER      = HALF_TURN / 2;
    localparam int          SERIES_TERMS = 12;
    localparam int          DRAIN_WAIT   = 20;
    localparam int          CYCLE_LIMIT  = 100000;
    localparam int          IDLE_PCT     = 34;

    typedef logic [63:0]        t_u64;
    typedef logic signed [63:0] t_s64;

    localparam t_u64 PI_SCALED = 64'd3373259426;

    typedef struct packed {
        epr_pkg::t_op    op;
        epr_pkg::t_coord px;
        epr_pkg::t_coord py;
        epr_pkg::t_coord pz;
        epr_pkg::t_ang   a_yz;
        epr_pkg::t_ang   a_xz;
        epr_pkg::t_ang   a_xy;
    } t_point_req;

    typedef struct packed {
        epr_pkg::t_coord rx;
        epr_pkg::t_coord ry;
        epr_pkg::t_coord rz;
        logic            clipped;
    } t_rotated;

    typedef struct packed {
        epr_pkg::t_coord u;
        epr_pkg::t_coord v;
        logic            clip;
    } t_plane;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            i_op       = 1'b0;
    epr_pkg::t_coord i_px       = '0;
    epr_pkg::t_coord i_py       = '0;
    epr_pkg::t_coord i_pz       = '0;
    epr_pkg::t_ang   i_angle_yz = '0;
    epr_pkg::t_ang   i_angle_xz = '0;
    epr_pkg::t_ang   i_angle_xy = '0;
    logic            i_out_ready = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    epr_pkg::t_coord o_rx;
    epr_pkg::t_coord o_ry;
    epr_pkg::t_coord o_rz;
    logic            o_clipped;

    epr_pkg::t_coef sine_tab [FULL_TURN];
    t_rotated       expected_rotations [$];

    bit src_idle_en   = 1'b0;
    bit sink_stall_en = 1'b0;
    int sink_hold_req = 0;
    int err_count     = 0;
    int cycle_count   = 0;
    int n_fwd         = 0;
    int n_rev         = 0;
    int n_results     = 0;
    int n_clipped     = 0;
    int n_in_stall    = 0;

    euler_point_rotator_core #(
        .HALF_TURN(HALF_TURN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_px       (i_px),
        .i_py       (i_py),
        .i_pz       (i_pz),
        .i_angle_yz (i_angle_yz),
        .i_angle_xz (i_angle_xz),
        .i_angle_xy (i_angle_xy),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_rx       (o_rx),
        .o_ry       (o_ry),
        .o_rz       (o_rz),
        .o_clipped  (o_clipped)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic epr_pkg::t_coef quadrant_sine(int unsigned n);
        t_u64 theta;
        t_u64 term;
        t_u64 r;
        t_s64 sum;
        theta = (PI_SCALED * t_u64'(n)) / t_u64'(HALF_TURN);
        term  = theta;
        sum   = $signed(theta);
        for (int i = 1; i <= SERIES_TERMS; i++) begin
            term = (term * theta) >> 30;
            term = (term * theta) >> 30;
            term = term / t_u64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = ($unsigned(sum) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return epr_pkg::t_coef'(r[15:0]);
    endfunction

    function automatic void build_sine_table();
        int unsigned    n;
        bit             neg;
        epr_pkg::t_coef v;
        for (int unsigned k = 0; k < FULL_TURN; k++) begin
            n   = k;
            neg = 1'b0;
            if (n >= HALF_TURN) begin
                n   = n - HALF_TURN;
                neg = 1'b1;
            end
            if (n > QUARTER) begin
                n = HALF_TURN - n;
            end
            v = quadrant_sine(n);
            sine_tab[k] = neg ? -v : v;
        end
    endfunction

    function automatic t_s64 rom_value(int unsigned idx);
        t_s64 v;
        v = sine_tab[idx & ANG_MASK];
        return v;
    endfunction

    // returns {saturated, value}
    function automatic logic [16:0] shrink_q15(t_s64 acc);
        t_s64 q;
        q = acc / 64'sd32768;
        if (q > 64'sd32767) begin
            return {1'b1, 16'h7FFF};
        end
        if (q < -64'sd32768) begin
            return {1'b1, 16'h8000};
        end
        return {1'b0, q[15:0]};
    endfunction

    // (u, v) -> (c*u - s*v, c*v + s*u)
    function automatic t_plane turn_plane(int unsigned idx, t_plane pair);
        t_s64        s;
        t_s64        c;
        t_s64        u;
        t_s64        v;
        logic [16:0] nu;
        logic [16:0] nv;
        t_plane      res;
        s  = rom_value(idx);
        c  = rom_value(idx + QUARTER);
        u  = pair.u;
        v  = pair.v;
        nu = shrink_q15(c * u - s * v);
        nv = shrink_q15(c * v + s * u);
        res.u    = nu[15:0];
        res.v    = nv[15:0];
        res.clip = pair.clip | nu[16] | nv[16];
        return res;
    endfunction

    function automatic int unsigned back_angle(epr_pkg::t_ang a);
        return (FULL_TURN - int'(a)) & ANG_MASK;
    endfunction

    function automatic t_rotated rotate_point(t_point_req p);
        t_plane          st;
        epr_pkg::t_coord x;
        epr_pkg::t_coord y;
        epr_pkg::t_coord z;
        t_rotated        res;
        x = p.px;
        y = p.py;
        z = p.pz;
        if (p.op == epr_pkg::OP_FWD) begin
            st = turn_plane(int'(p.a_yz) & ANG_MASK, '{u: y, v: z, clip: 1'b0});
            y  = st.u;
            z  = st.v;
            st = turn_plane(int'(p.a_xz) & ANG_MASK, '{u: x, v: z, clip: st.clip});
            x  = st.u;
            z  = st.v;
            st = turn_plane(int'(p.a_xy) & ANG_MASK, '{u: x, v: y, clip: st.clip});
            x  = st.u;
            y  = st.v;
        end else begin
            st = turn_plane(back_angle(p.a_xy), '{u: x, v: y, clip: 1'b0});
            x  = st.u;
            y  = st.v;
            st = turn_plane(back_angle(p.a_xz), '{u: x, v: z, clip: st.clip});
            x  = st.u;
            z  = st.v;
            st = turn_plane(back_angle(p.a_yz), '{u: y, v: z, clip: st.clip});
            y  = st.u;
            z  = st.v;
        end
        res.rx      = x;
        res.ry      = y;
        res.rz      = z;
        res.clipped = st.clip;
        return res;
    endfunction

    function automatic t_point_req make_point(epr_pkg::t_op op, int x, int y, int z,
                                              int ayz, int axz, int axy);
        t_point_req p;
        p.op   = op;
        p.px   = epr_pkg::t_coord'(x);
        p.py   = epr_pkg::t_coord'(y);
        p.pz   = epr_pkg::t_coord'(z);
        p.a_yz = epr_pkg::t_ang'(ayz);
        p.a_xz = epr_pkg::t_ang'(axz);
        p.a_xy = epr_pkg::t_ang'(axy);
        return p;
    endfunction

    function automatic epr_pkg::t_coord pick_coord();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1: return epr_pkg::t_coord'($urandom_range(510) - 255);
            default: return epr_pkg::t_coord'($urandom);
        endcase
    endfunction

    function automatic epr_pkg::t_ang pick_angle();
        if ($urandom_range(4) == 0) begin
            return epr_pkg::t_ang'($urandom_range(3) * QUARTER + $urandom_range(2) - 1);
        end
        return epr_pkg::t_ang'($urandom);
    endfunction

    function automatic t_point_req pick_point();
        t_point_req p;
        p.op   = epr_pkg::t_op'($urandom_range(1));
        p.px   = pick_coord();
        p.py   = pick_coord();
        p.pz   = pick_coord();
        p.a_yz = pick_angle();
        p.a_xz = pick_angle();
        p.a_xy = pick_angle();
        return p;
    endfunction

    task automatic send_point(t_point_req p);
        if (src_idle_en) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_op       <= p.op;
        i_px       <= p.px;
        i_py       <= p.py;
        i_pz       <= p.pz;
        i_angle_yz <= p.a_yz;
        i_angle_xz <= p.a_xz;
        i_angle_xy <= p.a_xy;
        do @(posedge i_clk); while (!o_in_ready);
        expected_rotations.push_back(rotate_point(p));
        if (p.op == epr_pkg::OP_FWD) begin
            n_fwd++;
        end else begin
            n_rev++;
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_rotations.size() != 0);
    endtask

    task automatic test_directed_cases();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        send_point(make_point(epr_pkg::OP_FWD, 0, 0, 0, 0, 0, 0));
        send_point(make_point(epr_pkg::OP_FWD, 1000, 2000, 3000, 0, 0, 0));
        send_point(make_point(epr_pkg::OP_FWD, 32767, 32767, 32767, 0, 0, 0));
        send_point(make_point(epr_pkg::OP_FWD, -32768, -32768, -32768, 0, 0, 0));
        send_point(make_point(epr_pkg::OP_FWD, 32767, -32768, 32767, 128, 128, 128));
        send_point(make_point(epr_pkg::OP_REV, 32767, -32768, 32767, 128, 128, 128));
        send_point(make_point(epr_pkg::OP_REV, -32768, -32768, -32768, 896, 384, 640));
        send_point(make_point(epr_pkg::OP_FWD, 100, 200, 300, QUARTER, 0, 0));
        send_point(make_point(epr_pkg::OP_FWD, 100, 200, 300, 0, QUARTER, 0));
        send_point(make_point(epr_pkg::OP_FWD, 100, 200, 300, 0, 0, QUARTER));
        send_point(make_point(epr_pkg::OP_REV, 100, 200, 300, QUARTER, QUARTER, QUARTER));
        send_point(make_point(epr_pkg::OP_FWD, -5000, 7000, -9000, HALF_TURN, HALF_TURN,
                              HALF_TURN));
        send_point(make_point(epr_pkg::OP_FWD, -5000, 7000, -9000, 3 * QUARTER, 3 * QUARTER,
                              3 * QUARTER));
        send_point(make_point(epr_pkg::OP_REV, -5000, 7000, -9000, HALF_TURN, 3 * QUARTER, 0));
        send_point(make_point(epr_pkg::OP_FWD, 4321, -1234, 32767, 1023, 1, 1023));
        send_point(make_point(epr_pkg::OP_REV, 4321, -1234, 32767, 1023, 1, 1023));
        send_point(make_point(epr_pkg::OP_REV, 32767, 0, -32768, 0, 0, 0));
        send_point(make_point(epr_pkg::OP_FWD, -1, 1, -1, 77, 300, 900));
        send_point(make_point(epr_pkg::OP_REV, -1, 1, -1, 77, 300, 900));
        send_point(make_point(epr_pkg::OP_FWD, 12345, -23456, 30000, 345, 678, 1000));
        send_point(make_point(epr_pkg::OP_REV, 12345, -23456, 30000, 345, 678, 1000));
        wait_for_results();
    endtask

    task automatic test_back_to_back(int count);
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        repeat (count) send_point(pick_point());
        wait_for_results();
    endtask

    task automatic test_output_backpressure(int count);
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        sink_hold_req = 60;
        repeat (count) send_point(pick_point());
        wait_for_results();
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++) begin
            src_idle_en   = (i % 260) < 200;
            sink_stall_en = ((i + 100) % 260) < 200;
            send_point(pick_point());
        end
        wait_for_results();
    endtask

    always @(posedge i_clk) begin
        if (sink_hold_req > 0) begin
            i_out_ready <= 1'b0;
            sink_hold_req = sink_hold_req - 1;
        end else if (sink_stall_en) begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rotated exp_r;
        if (i_rst_n && i_in_valid && !o_in_ready) begin
            n_in_stall++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rotations.size() == 0) begin
                $error("unexpected result: rx %0d ry %0d rz %0d clipped %0b",
                       o_rx, o_ry, o_rz, o_clipped);
                err_count++;
            end else begin
                exp_r = expected_rotations.pop_front();
                n_results++;
                if (exp_r.clipped) begin
                    n_clipped++;
                end
                if (o_rx !== exp_r.rx) begin
                    $error("rx: expected %0d, actual %0d", exp_r.rx, o_rx);
                    err_count++;
                end
                if (o_ry !== exp_r.ry) begin
                    $error("ry: expected %0d, actual %0d", exp_r.ry, o_ry);
                    err_count++;
                end
                if (o_rz !== exp_r.rz) begin
                    $error("rz: expected %0d, actual %0d", exp_r.rz, o_rz);
                    err_count++;
                end
                if (o_clipped !== exp_r.clipped) begin
                    $error("clipped: expected %0b, actual %0b", exp_r.clipped, o_clipped);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        build_sine_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_back_to_back(200);
        test_output_backpressure(40);
        test_random_traffic(1040);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_rotations.size() != 0) begin
            $error("%0d results never arrived", expected_rotations.size());
            err_count++;
        end
        $display("tb: %0d requests (%0d forward, %0d reverse), %0d results, %0d saturated",
                 n_fwd + n_rev, n_fwd, n_rev, n_results, n_clipped);
        $display("tb: %0d cycles of input stall, %0d errors", n_in_stall, err_count);
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
